[hw/rtl/ddpid_pkg.sv]
// Shared constants and types for the differential drive position controller.
package ddpid_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned IW = 48;

  localparam logic signed [IW-1:0] I48_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] I48_MIN = {1'b1, {(IW-1){1'b0}}};
  localparam logic signed [QW-1:0] CMD_LIMIT = 32'sd26214400;   // 400.0
  localparam logic signed [QW-1:0] MIN_DRIVE = 32'sd5242880;    // 80.0
  localparam logic signed [QW-1:0] TURN_GATE = 32'sd1310720;    // 20.0
  localparam logic signed [QW-1:0] HEAD_BAND = 32'sd6554;       // 0.1
  localparam logic signed [QW-1:0] DIST_BAND = 32'sd32768;      // 0.5

  localparam logic [2:0] REG_TGT_HEAD = 3'd0;
  localparam logic [2:0] REG_TGT_DIST = 3'd1;
  localparam logic [2:0] REG_H_KP = 3'd2;
  localparam logic [2:0] REG_H_KI = 3'd3;
  localparam logic [2:0] REG_H_KD = 3'd4;
  localparam logic [2:0] REG_D_KP = 3'd5;
  localparam logic [2:0] REG_D_KI = 3'd6;
  localparam logic [2:0] REG_D_KD = 3'd7;

  typedef logic signed [63:0] wide_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [QW-1:0] sat32(input wide_t x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[QW-1:0];
  endfunction

  // Saturate a wide signed value to 48 bits.
  function automatic logic signed [IW-1:0] sat48(input wide_t x);
    if (x > 64'(I48_MAX)) return I48_MAX;
    if (x < 64'(I48_MIN)) return I48_MIN;
    return x[IW-1:0];
  endfunction

endpackage

[hw/rtl/diff_drive_dual_pid.sv]
// Top level of the differential drive dual PID position controller.
//
//  channel | signals                                          | direction
//  cfg     | cfg_we, cfg_index, cfg_data                      | in
//  in      | in_valid, in_stall, restart, count_*, settle_tick| in (stall out)
//  out     | out_valid, out_stall, speed_*, done_res, advancing| out (stall in)
//
// The result is valid after the heading loop and then, unless the heading
// command keeps it from running, the distance loop; one shared 34x33 signed
// multiplier is stepped through position scaling and the six gain products.
// The input stalls from acceptance until its result has been taken.
// rst is synchronous; it clears the sequencer, loop state and config registers.
// A stalled result holds in the output register.
module diff_drive_dual_pid
  import ddpid_pkg::*;
#(
  parameter int MAX_DRIVE       = 400,
  parameter int DIST_PER_COUNT  = 631360,
  parameter int ANGLE_PER_COUNT = 2254857
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               restart,
  input  logic signed [31:0] count_left,
  input  logic signed [31:0] count_right,
  input  logic               settle_tick,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [9:0]  speed_left,
  output logic signed [9:0]  speed_right,
  output logic               done_res,
  output logic               advancing
);

  localparam logic [3:0] S_IDLE = 4'd0,  S_MH = 4'd1,  S_MD = 4'd2,  S_HERR = 4'd3,
                         S_HP = 4'd4,    S_HI = 4'd5,  S_HD = 4'd6,  S_HOUT = 4'd7,
                         S_DERR = 4'd8,  S_DP = 4'd9,  S_DI = 4'd10, S_DD = 4'd11,
                         S_DOUT = 4'd12, S_MIX = 4'd13, S_OUT = 4'd14;
  localparam logic signed [63:0] WLIM = 64'(MAX_DRIVE) * 64'sd131072;

  logic [3:0] state;
  logic signed [31:0] tgt_head, tgt_dist;
  logic [15:0] h_kp, h_ki, h_kd, d_kp, d_ki, d_kd;
  logic signed [IW-1:0] h_int, d_int;
  logic signed [31:0] h_prev, d_prev, turn_cmd, fwd_cmd, d_off, last_l, last_r;
  logic offset_pending;
  logic signed [31:0] dist_pos, err;
  logic signed [32:0] diff_lr, sum_lr;
  logic signed [63:0] pterm, dterm;
  logic adv;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] prod;
  assign prod = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MH: begin mul_a = 34'(diff_lr); mul_b = 33'(ANGLE_PER_COUNT); end
      S_MD: begin mul_a = 34'(sum_lr);  mul_b = 33'(DIST_PER_COUNT); end
      S_HP: begin mul_a = 34'(err); mul_b = {17'd0, h_kp}; end
      S_HI: begin mul_a = 34'(err); mul_b = {17'd0, h_ki}; end
      S_HD: begin mul_a = 34'(err) - 34'(h_prev); mul_b = {17'd0, h_kd}; end
      S_DP: begin mul_a = 34'(err); mul_b = {17'd0, d_kp}; end
      S_DI: begin mul_a = 34'(err); mul_b = {17'd0, d_ki}; end
      S_DD: begin mul_a = 34'(err) - 34'(d_prev); mul_b = {17'd0, d_kd}; end
      default: ;
    endcase
  end

  logic signed [63:0] psh8;
  assign psh8 = 64'(prod >>> 8);

  // PID output: clamp, then minimum drive outside the deadband
  function automatic logic signed [31:0] pid_out(input logic signed [63:0] s,
      input logic signed [31:0] e, input logic signed [31:0] band);
    logic signed [31:0] o;
    o = (s > 64'(CMD_LIMIT)) ? CMD_LIMIT :
        (s < -64'(CMD_LIMIT)) ? -CMD_LIMIT : s[31:0];
    if (e > band && o < MIN_DRIVE) o = MIN_DRIVE;
    if (e < -band && o > -MIN_DRIVE) o = -MIN_DRIVE;
    return o;
  endfunction

  function automatic logic signed [9:0] wheel(input logic signed [63:0] t);
    logic signed [63:0] c;
    logic signed [63:0] m;
    c = (t > WLIM) ? WLIM : (t < -WLIM) ? -WLIM : t;
    m = (c < 0) ? -c : c;
    m = m >>> 17;
    return (c < 0) ? 10'(-m) : 10'(m);
  endfunction

  logic signed [63:0] hsum, dsum;
  assign hsum = pterm + 64'(h_int) + dterm;
  assign dsum = pterm + 64'(d_int) + dterm;

  assign in_stall = (state != S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_head <= '0; tgt_dist <= '0;
      h_kp <= '0; h_ki <= '0; h_kd <= '0; d_kp <= '0; d_ki <= '0; d_kd <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TGT_HEAD: tgt_head <= cfg_data;
        REG_TGT_DIST: tgt_dist <= cfg_data;
        REG_H_KP: h_kp <= cfg_data[15:0];
        REG_H_KI: h_ki <= cfg_data[15:0];
        REG_H_KD: h_kd <= cfg_data[15:0];
        REG_D_KP: d_kp <= cfg_data[15:0];
        REG_D_KI: d_ki <= cfg_data[15:0];
        REG_D_KD: d_kd <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      h_int <= '0; d_int <= '0; h_prev <= '0; d_prev <= '0;
      turn_cmd <= '0; fwd_cmd <= '0; d_off <= '0; offset_pending <= 1'b1;
      last_l <= '0; last_r <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          diff_lr <= 33'(count_left) - 33'(count_right);
          sum_lr <= 33'(count_left) + 33'(count_right);
          adv <= 1'b0;
          done_res <= 1'b0;
          if (settle_tick) begin
            done_res <= (count_left == last_l) && (count_right == last_r);
            last_l <= count_left;
            last_r <= count_right;
          end
          if (restart) begin
            h_int <= '0; d_int <= '0; h_prev <= '0; d_prev <= '0;
            turn_cmd <= '0; fwd_cmd <= '0; d_off <= '0; offset_pending <= 1'b1;
          end
          state <= S_MH;
        end
        S_MH: begin
          err <= sat32(64'(prod >>> 16));
          state <= S_MD;
        end
        S_MD: begin
          dist_pos <= sat32(64'(prod >>> 17));
          state <= S_HERR;
        end
        S_HERR: begin
          err <= sat32(64'(tgt_head) - 64'(err));
          state <= S_HP;
        end
        S_HP: begin pterm <= psh8; state <= S_HI; end
        S_HI: begin h_int <= sat48(64'(h_int) + psh8); state <= S_HD; end
        S_HD: begin dterm <= psh8; h_prev <= err; state <= S_HOUT; end
        S_HOUT: begin
          turn_cmd <= pid_out(hsum, err, HEAD_BAND);
          state <= S_DERR;
        end
        S_DERR: begin
          if (turn_cmd < TURN_GATE && turn_cmd > -TURN_GATE) begin
            adv <= 1'b1;
            if (offset_pending) begin
              d_off <= dist_pos;
              offset_pending <= 1'b0;
              err <= sat32(64'(tgt_dist));
            end else begin
              err <= sat32(64'(tgt_dist) - 64'(sat32(64'(dist_pos) - 64'(d_off))));
            end
            state <= S_DP;
          end else begin
            state <= S_MIX;
          end
        end
        S_DP: begin pterm <= psh8; state <= S_DI; end
        S_DI: begin d_int <= sat48(64'(d_int) + psh8); state <= S_DD; end
        S_DD: begin dterm <= psh8; d_prev <= err; state <= S_DOUT; end
        S_DOUT: begin
          fwd_cmd <= pid_out(dsum, err, DIST_BAND);
          state <= S_MIX;
        end
        S_MIX: begin
          speed_left <= wheel(64'(fwd_cmd) + 64'(turn_cmd));
          speed_right <= wheel(64'(fwd_cmd) - 64'(turn_cmd));
          advancing <= adv;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
